// ===== rtl/rle_pixel_run_to_rect_fill_core_assert.svh =====
// assertion macros for the run-length to rectangle fill core
// used by the port checker, needs nothing else
`ifndef RLE_PIXEL_RUN_TO_RECT_FILL_CORE_ASSERT_SVH
`define RLE_PIXEL_RUN_TO_RECT_FILL_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RLERF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RLERF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rlerf_pkg.sv =====
// shared types and constants of the run-length to rectangle fill core
// no dependencies
package rlerf_pkg;

	localparam int unsigned FIELD_W = 16;
	localparam int unsigned TOTAL_W = 32;
	localparam int unsigned LW_W    = 11;
	localparam int unsigned OFS_W   = 10;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 11'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH = 2'd0,
		REG_X_OFFSET   = 2'd1,
		REG_Y_OFFSET   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

	// how many rectangles a run produces
	typedef enum logic [1:0] {
		FILL_ONE,
		FILL_TWO,
		FILL_THREE
	} fill_kind_t;

	typedef struct packed {
		logic [FIELD_W-1:0] x_start;
		logic [FIELD_W-1:0] y_start;
		logic [FIELD_W-1:0] x_end;
		logic [FIELD_W-1:0] y_end;
		logic [FIELD_W-1:0] color;
		logic               last;
	} rect_t;

endpackage

// ===== rtl/rlerf_if.sv =====
// valid/ready channels for run records and fill rectangles
// depends on rlerf_pkg
interface rlerf_run_if;
	logic                          valid;
	logic                          ready;
	logic                          start_of_image;
	logic [rlerf_pkg::FIELD_W-1:0] run_color;
	logic [rlerf_pkg::FIELD_W-1:0] run_length;

	modport source (output valid, start_of_image, run_color, run_length, input ready);
	modport sink (input valid, start_of_image, run_color, run_length, output ready);
endinterface

interface rlerf_rect_if;
	logic                          valid;
	logic                          ready;
	logic [rlerf_pkg::FIELD_W-1:0] rect_x_start;
	logic [rlerf_pkg::FIELD_W-1:0] rect_y_start;
	logic [rlerf_pkg::FIELD_W-1:0] rect_x_end;
	logic [rlerf_pkg::FIELD_W-1:0] rect_y_end;
	logic [rlerf_pkg::FIELD_W-1:0] fill_color;
	logic                          last_fill;

	modport source (output valid, rect_x_start, rect_y_start, rect_x_end, rect_y_end,
		fill_color, last_fill, input ready);
	modport sink (input valid, rect_x_start, rect_y_start, rect_x_end, rect_y_end,
		fill_color, last_fill, output ready);
endinterface

// ===== rtl/rle_pixel_run_to_rect_fill_core.sv =====
// run-length record to rectangle fill converter, top level
// depends on rlerf_pkg and the channel interfaces in rlerf_if.sv
//
// Each run record is added into the 32-bit pixel total as the record is taken.
// Then comes a bit-serial restoring divide of the total by the line width, one
// quotient bit per cycle, a step to add the offsets and the load of the first
// rectangle into the output register. Each further rectangle is loaded as soon
// as the output register is empty or its rectangle is taken. A new record is
// taken once the last rectangle of the previous one sits in the output register,
// even if it has not been taken yet. Register writes are allowed only between
// records; line_width 0 acts as 1 and values above MAX_LINE_WIDTH act as
// MAX_LINE_WIDTH.
module rle_pixel_run_to_rect_fill_core #(
	parameter int unsigned MAX_LINE_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [rlerf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rlerf_pkg::LW_W-1:0]      cfg_data,
	rlerf_run_if.sink                       runs,
	rlerf_rect_if.source                    rects
);

	localparam int unsigned WW = $clog2(MAX_LINE_WIDTH + 1);
	localparam int unsigned FW = rlerf_pkg::FIELD_W;
	localparam int unsigned TW = rlerf_pkg::TOTAL_W;
	localparam logic [4:0] LAST_STEP = 5'(TW - 1);

	// configuration
	logic [rlerf_pkg::LW_W-1:0]  line_width_q;
	logic [rlerf_pkg::OFS_W-1:0] x_offset_q;
	logic [rlerf_pkg::OFS_W-1:0] y_offset_q;

	// run state
	logic [TW-1:0] pixel_total_q;
	logic [FW-1:0] prev_column_q;
	logic [FW-1:0] prev_row_q;
	logic [FW-1:0] color_q;

	// divider
	logic [WW-1:0] w_q;
	logic [WW-1:0] w_eff;
	logic [TW-1:0] dvd_q;
	logic [WW-1:0] rem_q;
	logic [4:0]    step_q;
	logic [WW:0]   trial;
	logic          q_bit;

	// end point and emission
	logic [FW-1:0] col_q;
	logic [FW-1:0] row_q;
	logic [1:0]    idx_q;
	logic [FW-1:0] row_edge;
	logic [FW-1:0] x_ofs16;
	logic [TW-1:0] total_next;
	rlerf_pkg::fill_kind_t kind;
	rlerf_pkg::rect_t      rect_d;
	rlerf_pkg::rect_t      rect_q;
	logic                  out_valid_q;

	rlerf_pkg::state_t state_q, state_d;
	logic accept;
	logic load_out;
	logic div_done;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= rlerf_pkg::LINE_WIDTH_RESET;
			x_offset_q   <= '0;
			y_offset_q   <= '0;
		end else if (cfg_write) begin
			unique case (rlerf_pkg::cfg_reg_t'(cfg_index))
				rlerf_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data;
				rlerf_pkg::REG_X_OFFSET:   x_offset_q <= cfg_data[rlerf_pkg::OFS_W-1:0];
				rlerf_pkg::REG_Y_OFFSET:   y_offset_q <= cfg_data[rlerf_pkg::OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (line_width_q == '0)
			w_eff = WW'(1);
		else if (32'(line_width_q) > 32'(MAX_LINE_WIDTH))
			w_eff = WW'(MAX_LINE_WIDTH);
		else
			w_eff = WW'(line_width_q);
	end

	assign x_ofs16    = FW'(x_offset_q);
	assign row_edge   = FW'(w_q) - FW'(1) + x_ofs16;
	assign total_next = (runs.start_of_image ? '0 : pixel_total_q) + TW'(runs.run_length);

	// one restoring divide step per cycle
	assign trial    = {rem_q, dvd_q[TW-1]};
	assign q_bit    = (trial >= {1'b0, w_q});
	assign div_done = (step_q == LAST_STEP);

	// fill count from the end row against the previous row
	always_comb begin
		if (row_q > prev_row_q) begin
			if ({1'b0, row_q} > ({1'b0, prev_row_q} + 17'd1))
				kind = rlerf_pkg::FILL_THREE;
			else
				kind = rlerf_pkg::FILL_TWO;
		end else begin
			kind = rlerf_pkg::FILL_ONE;
		end
	end

	always_comb begin
		rect_d.color = color_q;
		unique case (kind)
			rlerf_pkg::FILL_ONE: begin
				rect_d.x_start = prev_column_q;
				rect_d.y_start = prev_row_q;
				rect_d.x_end   = col_q;
				rect_d.y_end   = row_q;
				rect_d.last    = 1'b1;
			end
			rlerf_pkg::FILL_TWO: begin
				if (idx_q == 2'd0) begin
					rect_d.x_start = prev_column_q;
					rect_d.y_start = prev_row_q;
					rect_d.x_end   = row_edge;
					rect_d.y_end   = row_q - FW'(1);
					rect_d.last    = 1'b0;
				end else begin
					rect_d.x_start = x_ofs16;
					rect_d.y_start = row_q;
					rect_d.x_end   = col_q;
					rect_d.y_end   = row_q;
					rect_d.last    = 1'b1;
				end
			end
			default: begin
				priority case (idx_q)
					2'd0: begin
						rect_d.x_start = prev_column_q;
						rect_d.y_start = prev_row_q;
						rect_d.x_end   = row_edge;
						rect_d.y_end   = prev_row_q;
						rect_d.last    = 1'b0;
					end
					2'd1: begin
						// full middle rows
						rect_d.x_start = x_ofs16;
						rect_d.y_start = prev_row_q + FW'(1);
						rect_d.x_end   = row_edge;
						rect_d.y_end   = row_q - FW'(1);
						rect_d.last    = 1'b0;
					end
					default: begin
						rect_d.x_start = x_ofs16;
						rect_d.y_start = row_q;
						rect_d.x_end   = col_q;
						rect_d.y_end   = row_q;
						rect_d.last    = 1'b1;
					end
				endcase
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rlerf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		runs.ready = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			rlerf_pkg::ST_IDLE: begin
				runs.ready = 1'b1;
				if (runs.valid)
					state_d = rlerf_pkg::ST_DIV;
			end
			rlerf_pkg::ST_DIV: begin
				if (div_done)
					state_d = rlerf_pkg::ST_FIN;
			end
			rlerf_pkg::ST_FIN: begin
				state_d = rlerf_pkg::ST_EMIT;
			end
			rlerf_pkg::ST_EMIT: begin
				load_out = !out_valid_q || rects.ready;
				if (load_out && rect_d.last)
					state_d = rlerf_pkg::ST_IDLE;
			end
			default: state_d = rlerf_pkg::ST_IDLE;
		endcase
	end

	assign accept = runs.valid && runs.ready;

	// run state and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_total_q <= '0;
			prev_column_q <= '0;
			prev_row_q    <= '0;
			step_q        <= '0;
			idx_q         <= '0;
		end else begin
			if (accept) begin
				pixel_total_q <= total_next;
				step_q        <= '0;
				idx_q         <= '0;
				if (runs.start_of_image) begin
					prev_column_q <= x_ofs16;
					prev_row_q    <= FW'(y_offset_q);
				end
			end
			if (state_q == rlerf_pkg::ST_DIV)
				step_q <= step_q + 5'd1;
			if (load_out) begin
				idx_q <= idx_q + 2'd1;
				if (rect_d.last) begin
					prev_column_q <= col_q;
					prev_row_q    <= row_q;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			dvd_q   <= total_next;
			rem_q   <= '0;
			w_q     <= w_eff;
			color_q <= runs.run_color;
		end else if (state_q == rlerf_pkg::ST_DIV) begin
			dvd_q <= {dvd_q[TW-2:0], q_bit};
			rem_q <= q_bit ? WW'(trial - {1'b0, w_q}) : trial[WW-1:0];
		end
		if (state_q == rlerf_pkg::ST_FIN) begin
			col_q <= FW'(rem_q) + x_ofs16;
			row_q <= dvd_q[FW-1:0] + FW'(y_offset_q);
		end
		if (load_out)
			rect_q <= rect_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (rects.ready)
			out_valid_q <= 1'b0;
	end

	assign rects.valid        = out_valid_q;
	assign rects.rect_x_start = rect_q.x_start;
	assign rects.rect_y_start = rect_q.y_start;
	assign rects.rect_x_end   = rect_q.x_end;
	assign rects.rect_y_end   = rect_q.y_end;
	assign rects.fill_color   = rect_q.color;
	assign rects.last_fill    = rect_q.last;

endmodule

// ===== rtl/rlerf_checker.sv =====
// port-level checks for the run-length to rectangle fill core, with its bind
// depends on rlerf_pkg and rle_pixel_run_to_rect_fill_core_assert.svh
`include "rle_pixel_run_to_rect_fill_core_assert.svh"

module rlerf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          run_valid,
	input logic                          run_ready,
	input logic                          rect_valid,
	input logic                          rect_ready,
	input logic [rlerf_pkg::FIELD_W-1:0] rect_x_start,
	input logic [rlerf_pkg::FIELD_W-1:0] rect_x_end,
	input logic                          last_fill
);

	// a stalled rectangle holds
	`RLERF_ASSERT_NEXT(a_rect_hold, clk, arst_n, rect_valid && !rect_ready, rect_valid && $stable(rect_x_start) && $stable(rect_x_end) && $stable(last_fill), "rectangle changed while stalled")

	// one record at a time: busy right after a transfer
	`RLERF_ASSERT_NEXT(a_busy_after_run, clk, arst_n, run_valid && run_ready, !run_ready, "run taken while a record is in work")

	// no new record while the current one still has rectangles to come
	`RLERF_ASSERT_NOW(a_no_run_mid_record, clk, arst_n, rect_valid && !last_fill, !run_ready, "run taken before last rectangle of record")

endmodule

bind rle_pixel_run_to_rect_fill_core rlerf_checker u_rlerf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.run_valid    (runs.valid),
	.run_ready    (runs.ready),
	.rect_valid   (rects.valid),
	.rect_ready   (rects.ready),
	.rect_x_start (rects.rect_x_start),
	.rect_x_end   (rects.rect_x_end),
	.last_fill    (rects.last_fill)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the run-length to rectangle fill core
// needs rlerf_pkg, the channel interfaces in rlerf_if.sv and the core itself
// checks every rectangle against a predictor of the run split into row bands
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rlerf_pkg::*;

	localparam int unsigned MAX_W = 1024;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned SETTLE_CYCLES = 45;

	typedef struct packed {
		logic               sof;
		logic [FIELD_W-1:0] color;
		logic [FIELD_W-1:0] len;
	} run_rec_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LW_W-1:0]      cfg_data;

	rlerf_run_if  runs_ch ();
	rlerf_rect_if rects_ch ();

	rle_pixel_run_to_rect_fill_core #(
		.MAX_LINE_WIDTH(MAX_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.runs(runs_ch),
		.rects(rects_ch)
	);

	// register copies and running position seen by the predictor
	logic [LW_W-1:0]    width_reg;
	logic [OFS_W-1:0]   x_ofs_reg;
	logic [OFS_W-1:0]   y_ofs_reg;
	logic [TOTAL_W-1:0] pixel_sum;
	logic [FIELD_W-1:0] last_col;
	logic [FIELD_W-1:0] last_row;

	run_rec_t runs_pending[$];
	rect_t    rects_due[$];
	int       runs_queued;
	int       runs_taken;
	int       mismatch_count;
	int       cycle_count;
	logic     run_fired;
	int       run_gap;
	int       stall_left;
	int       gap_pct;
	int       stall_pct;
	logic     quiet;

	always #5 clk = ~clk;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_LINE_WIDTH;
		cfg_data = '0;
		runs_ch.valid = 1'b0;
		runs_ch.start_of_image = 1'b0;
		runs_ch.run_color = '0;
		runs_ch.run_length = '0;
		rects_ch.ready = 1'b0;
		width_reg = LINE_WIDTH_RESET;
		x_ofs_reg = '0;
		y_ofs_reg = '0;
		pixel_sum = '0;
		last_col = '0;
		last_row = '0;
		runs_queued = 0;
		runs_taken = 0;
		mismatch_count = 0;
		cycle_count = 0;
		run_fired = 1'b0;
		run_gap = 0;
		stall_left = 0;
		gap_pct = 20;
		stall_pct = 20;
		quiet = 1'b0;
	end

	function automatic logic [31:0] eff_width(logic [LW_W-1:0] lw);
		if (lw == '0)
			return 32'd1;
		if (lw > MAX_W)
			return MAX_W;
		return 32'(lw);
	endfunction

	function automatic rect_t make_rect(logic [31:0] xs, logic [31:0] ys, logic [31:0] xe,
		logic [31:0] ye, logic [FIELD_W-1:0] color, logic last);
		rect_t r;
		r.x_start = xs[FIELD_W-1:0];
		r.y_start = ys[FIELD_W-1:0];
		r.x_end = xe[FIELD_W-1:0];
		r.y_end = ye[FIELD_W-1:0];
		r.color = color;
		r.last = last;
		return r;
	endfunction

	// advance the pixel count and queue the row bands the run covers
	task automatic split_run_into_rects(run_rec_t rec);
		logic [31:0] w;
		logic [31:0] col;
		logic [31:0] row;
		logic [31:0] row_edge;
		logic [31:0] prow;
		w = eff_width(width_reg);
		if (rec.sof) begin
			pixel_sum = '0;
			last_col = 16'(x_ofs_reg);
			last_row = 16'(y_ofs_reg);
		end
		pixel_sum = pixel_sum + 32'(rec.len);
		col = (pixel_sum % w + 32'(x_ofs_reg)) & 32'hFFFF;
		row = (pixel_sum / w + 32'(y_ofs_reg)) & 32'hFFFF;
		row_edge = w - 32'd1 + 32'(x_ofs_reg);
		prow = 32'(last_row);
		if (row > prow + 32'd1) begin
			rects_due.push_back(make_rect(32'(last_col), prow, row_edge, prow, rec.color, 1'b0));
			rects_due.push_back(make_rect(32'(x_ofs_reg), prow + 32'd1, row_edge, row - 32'd1,
				rec.color, 1'b0));
			rects_due.push_back(make_rect(32'(x_ofs_reg), row, col, row, rec.color, 1'b1));
		end else if (row > prow) begin
			rects_due.push_back(make_rect(32'(last_col), prow, row_edge, row - 32'd1,
				rec.color, 1'b0));
			rects_due.push_back(make_rect(32'(x_ofs_reg), row, col, row, rec.color, 1'b1));
		end else begin
			// same row, or the row count wrapped past 16 bits
			rects_due.push_back(make_rect(32'(last_col), prow, col, row, rec.color, 1'b1));
		end
		last_col = col[FIELD_W-1:0];
		last_row = row[FIELD_W-1:0];
	endtask

	task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// input side: present queued runs, with random gaps between transfers
	always @(negedge clk) begin
		if (!arst_n) begin
			runs_ch.valid <= 1'b0;
		end else if (!runs_ch.valid || run_fired) begin
			if (run_gap > 0) begin
				run_gap--;
				runs_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
				run_gap = $urandom_range(0, 7);
				runs_ch.valid <= 1'b0;
			end else if (runs_pending.size() > 0) begin
				run_rec_t rec;
				rec = runs_pending.pop_front();
				runs_ch.start_of_image <= rec.sof;
				runs_ch.run_color <= rec.color;
				runs_ch.run_length <= rec.len;
				runs_ch.valid <= 1'b1;
			end else begin
				runs_ch.valid <= 1'b0;
			end
		end
	end

	// output side: random stall bursts on ready
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rects_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 7);
			rects_ch.ready <= 1'b0;
		end else begin
			rects_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		run_fired <= arst_n && runs_ch.valid && runs_ch.ready;
		if (arst_n && runs_ch.valid && runs_ch.ready) begin
			run_rec_t rec;
			rec.sof = runs_ch.start_of_image;
			rec.color = runs_ch.run_color;
			rec.len = runs_ch.run_length;
			split_run_into_rects(rec);
			runs_taken++;
		end
		if (arst_n && rects_ch.valid && rects_ch.ready) begin
			if (rects_due.size() == 0) begin
				$display("%0t: rectangle with none expected, expected nothing, actual %h %h %h %h %h %b",
					$time, rects_ch.rect_x_start, rects_ch.rect_y_start, rects_ch.rect_x_end,
					rects_ch.rect_y_end, rects_ch.fill_color, rects_ch.last_fill);
				mismatch_count++;
			end else begin
				rect_t want;
				want = rects_due.pop_front();
				check_field("rect_x_start", want.x_start, rects_ch.rect_x_start);
				check_field("rect_y_start", want.y_start, rects_ch.rect_y_start);
				check_field("rect_x_end", want.x_end, rects_ch.rect_x_end);
				check_field("rect_y_end", want.y_end, rects_ch.rect_y_end);
				check_field("fill_color", want.color, rects_ch.fill_color);
				check_field("last_fill", 16'(want.last), 16'(rects_ch.last_fill));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [LW_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_LINE_WIDTH: width_reg = value;
			REG_X_OFFSET: x_ofs_reg = value[OFS_W-1:0];
			REG_Y_OFFSET: y_ofs_reg = value[OFS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_regs(logic [LW_W-1:0] lw, logic [LW_W-1:0] xo, logic [LW_W-1:0] yo);
		write_reg(REG_LINE_WIDTH, lw);
		write_reg(REG_X_OFFSET, xo);
		write_reg(REG_Y_OFFSET, yo);
	endtask

	task automatic push_run(logic sof, logic [FIELD_W-1:0] color, logic [FIELD_W-1:0] len);
		run_rec_t rec;
		rec.sof = sof;
		rec.color = color;
		rec.len = len;
		runs_pending.push_back(rec);
		runs_queued++;
	endtask

	// hold off until every run is taken and every rectangle has arrived
	task automatic wait_drained();
		while (runs_taken != runs_queued || rects_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] pick_run_length(logic [31:0] w);
		logic [31:0] len;
		case ($urandom_range(0, 9))
			0, 1, 2: len = $urandom_range(0, 15);
			3, 4, 5: len = $urandom_range(0, 3 * w);
			6: len = w * $urandom_range(1, 4);
			default: len = $urandom_range(0, 65535);
		endcase
		if (len > 32'hFFFF)
			len = 32'hFFFF;
		return len[FIELD_W-1:0];
	endfunction

	initial begin
		logic [LW_W-1:0] lw;
		logic [LW_W-1:0] xo;
		logic [LW_W-1:0] yo;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: width 480, no offsets
		push_run(1'b0, 16'h0000, 16'd0);
		push_run(1'b0, 16'hFFFF, 16'd100);
		push_run(1'b0, 16'h1234, 16'd380);
		push_run(1'b0, 16'hF800, 16'd1500);
		push_run(1'b0, 16'hAAAA, 16'hFFFF);
		push_run(1'b0, 16'h5555, 16'd1);
		push_run(1'b1, 16'h07E0, 16'd479);
		wait_drained();

		// preview layout, width 200 shifted right by 270
		set_regs(11'd200, 11'd270, 11'd0);
		push_run(1'b1, 16'h001F, 16'd605);
		push_run(1'b0, 16'hC3C3, 16'd0);
		push_run(1'b0, 16'h3C3C, 16'd199);
		wait_drained();

		// width 0 acts as 1: each pixel is a row, rows wrap past 16 bits
		set_regs(11'd0, 11'd0, 11'd1023);
		push_run(1'b1, 16'h8001, 16'd1);
		push_run(1'b0, 16'h4002, 16'd5);
		push_run(1'b0, 16'h2004, 16'hFFFF);
		push_run(1'b0, 16'h1008, 16'hFFFF);
		push_run(1'b0, 16'h0810, 16'd0);
		wait_drained();

		// width above the maximum is clamped, offsets at their top
		set_regs(11'd2047, 11'd1023, 11'd1023);
		push_run(1'b1, 16'h0420, 16'd2048);
		push_run(1'b0, 16'h0240, 16'd1023);
		push_run(1'b0, 16'h0180, 16'hFFFF);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			xo = 11'($urandom_range(0, 1023));
			yo = 11'($urandom_range(0, 1023));
			lw = 11'($urandom_range(2, 1024));
			case (p)
				0: begin lw = 11'd480; xo = '0; yo = '0; gap_pct = 20; stall_pct = 20; end
				1: begin lw = 11'd1024; xo = '0; yo = '0; gap_pct = 0; stall_pct = 50; end
				2: begin lw = 11'd200; xo = 11'd270; yo = '0; gap_pct = 50; stall_pct = 0; end
				4: begin lw = 11'd1; yo = 11'd1023; gap_pct = 30; stall_pct = 30; end
				5: begin lw = 11'd1025; xo = 11'd1023; gap_pct = 10; stall_pct = 40; end
				7: begin quiet = 1'b1; gap_pct = 0; stall_pct = 0; end
				default: begin gap_pct = 20; stall_pct = 20; end
			endcase
			set_regs(lw, xo, yo);
			for (int i = 0; i < 52; i++)
				push_run(i == 0 || $urandom_range(0, 11) == 0, 16'($urandom_range(0, 65535)),
					pick_run_length(eff_width(lw)));
			wait_drained();
		end

		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== rle_pixel_run_to_rect_fill_core.f =====
+incdir+rtl
rtl/rlerf_pkg.sv
rtl/rlerf_if.sv
rtl/rle_pixel_run_to_rect_fill_core.sv
rtl/rlerf_checker.sv
tb/sv/testbench.sv
